// ===== hdl/mrpes_pkg.sv =====
// Shared types and constants for the multi-rate periodic event scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
package mrpes_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ENABLE  = 2'd1;
    localparam logic [1:0] OP_DISABLE = 2'd2;
    localparam logic [1:0] OP_START   = 2'd3;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int CH_W      = 3;
    localparam int CNT_W     = 4;
    localparam int PERIOD_W  = 16;
    localparam int MASK_W    = 6;
    localparam int TICK_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int MAX_CHANNELS    = 8;
    localparam int NUM_PERIOD_REGS = 6;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_IDX = 3'd6;

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] P_RST_MS [NUM_PERIOD_REGS] =
        '{16'd20, 16'd2000, 16'd500, 16'd10, 16'd20, 16'd20};
    localparam logic [MASK_W-1:0] P_RST_MASK = 6'd45;

    // parameter defaults
    localparam int DEF_NUM_CHANNELS   = 6;
    localparam int DEF_BASE_PERIOD_MS = 5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic            acc;        // an input word was accepted
        logic            acc_tick;   // accepted word is a tick
        logic            acc_en;     // accepted word is enable or disable
        logic            en_val;     // new enable bit
        logic [CH_W-1:0] en_ch;      // channel to enable or disable
        logic            walk_tick;  // evaluate channel walk_ch for firing
        logic            walk_start; // reload mark and enable of walk_ch
        logic [CH_W-1:0] walk_ch;
        logic            finish;     // emit the final result word
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic cfg_busy;              // period conversion in flight
    } t_dp_sts;

    // a period of zero base ticks counts as one
    function automatic logic [PERIOD_W-1:0] min1(input logic [PERIOD_W-1:0] x);
        return (x == '0) ? PERIOD_W'(1) : x;
    endfunction

endpackage

// ===== hdl/mrpes_ctrl.sv =====
// Sequencer of the scheduler: accepts words and walks the channels one a cycle.
// Depends on mrpes_pkg.
module mrpes_ctrl import mrpes_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [OP_W-1:0] i_opcode,
    input  logic [CH_W-1:0] i_channel,
    input  logic            i_cfg_we,
    input  t_dp_sts         i_sts,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    logic [1:0]      r_state, n_state;
    logic [CH_W-1:0] r_k, n_k;
    logic            r_is_start, n_is_start;
    logic            acc;

    assign busy = (r_state != S_IDLE) || i_sts.cfg_busy || i_cfg_we;
    assign acc  = start && !busy;

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_is_start = r_is_start;
        o_cmd      = '0;
        o_cmd.en_ch   = i_channel;
        o_cmd.en_val  = (i_opcode == OP_ENABLE);
        o_cmd.walk_ch = r_k;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.acc = 1'b1;
                    case (i_opcode)
                        OP_TICK: begin
                            o_cmd.acc_tick = 1'b1;
                            n_state        = S_WALK;
                            n_is_start     = 1'b0;
                        end
                        OP_START: begin
                            n_state    = S_WALK;
                            n_is_start = 1'b1;
                        end
                        default: begin
                            o_cmd.acc_en = 1'b1;
                            n_state      = S_FIN;
                        end
                    endcase
                    n_k = '0;
                end
            end
            S_WALK: begin
                o_cmd.walk_tick  = !r_is_start;
                o_cmd.walk_start = r_is_start;
                if (r_k == LAST_CH) begin
                    n_state = S_FIN;
                end else begin
                    n_k = r_k + CH_W'(1);
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_k        <= '0;
            r_is_start <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_k        <= n_k;
            r_is_start <= n_is_start;
        end
    end

endmodule

// ===== hdl/mrpes_dp.sv =====
// Datapath of the scheduler: registers, period conversion, marks and result word.
// Depends on mrpes_pkg.
module mrpes_dp import mrpes_pkg::*; #(
    parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
    parameter int BASE_PERIOD_MS = DEF_BASE_PERIOD_MS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_strobe,
    output logic                 o_fired,
    output logic [CH_W-1:0]      o_fired_channel,
    output logic [CNT_W-1:0]     o_fired_count,
    output logic                 o_last_result
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W = PERIOD_W + TICK_W + 1;
    // reciprocal of the base period, scaled by 2^32
    localparam logic [TICK_W:0] RECIP = (TICK_W + 1)'((64'd1 << TICK_W) / BASE_PERIOD_MS);
    localparam logic [PERIOD_W-1:0] BASE = PERIOD_W'(BASE_PERIOD_MS);
    localparam logic [PERIOD_W-1:0] RST_TICKS [MAX_CHANNELS] = '{
        min1(PERIOD_W'(P_RST_MS[0] / BASE_PERIOD_MS)),
        min1(PERIOD_W'(P_RST_MS[1] / BASE_PERIOD_MS)),
        min1(PERIOD_W'(P_RST_MS[2] / BASE_PERIOD_MS)),
        min1(PERIOD_W'(P_RST_MS[3] / BASE_PERIOD_MS)),
        min1(PERIOD_W'(P_RST_MS[4] / BASE_PERIOD_MS)),
        min1(PERIOD_W'(P_RST_MS[5] / BASE_PERIOD_MS)),
        PERIOD_W'(1),
        PERIOD_W'(1)
    };

    // configuration and channel state
    logic [MASK_W-1:0]   r_mask;
    logic [PERIOD_W-1:0] r_ticks [NUM_CHANNELS];
    logic [TICK_W-1:0]   r_mark  [NUM_CHANNELS];
    logic                r_en    [NUM_CHANNELS];
    logic [TICK_W-1:0]   r_tick_count;

    // period conversion pipe
    logic                 r_cv1_v, r_cv2_v;
    logic [PERIOD_W-1:0]  r_cv1_ms, r_cv2_ms;
    logic [CFG_IDX_W-1:0] r_cv1_idx, r_cv2_idx;
    logic [PROD_W-1:0]    r_prod;

    // pending firing, held until the next one shows whether it was the last
    logic              r_pend_v;
    logic [CH_W-1:0]   r_pend_ch;
    logic [CNT_W-1:0]  r_pend_cnt;

    logic              r_stb, r_fired, r_last;
    logic [CH_W-1:0]   r_och;
    logic [CNT_W-1:0]  r_ocnt;

    logic [PERIOD_W-1:0]         q0, q1, rem, cv_ticks;
    logic [PERIOD_W+IDX_W+9:0]   qb;
    logic [IDX_W-1:0]            wi, ei;
    logic [TICK_W-1:0]           diff;
    logic                        due;
    logic [MAX_CHANNELS-1:0]     mask_ext;

    // fix the low-by-one error of the reciprocal product
    assign q0       = r_prod[TICK_W +: PERIOD_W];
    assign qb       = (PERIOD_W + IDX_W + 10)'(q0) * (PERIOD_W + IDX_W + 10)'(BASE);
    assign rem      = r_cv2_ms - qb[PERIOD_W-1:0];
    assign q1       = (rem >= BASE) ? q0 + PERIOD_W'(1) : q0;
    assign cv_ticks = min1(q1);

    assign wi       = i_cmd.walk_ch[IDX_W-1:0];
    assign ei       = i_cmd.en_ch[IDX_W-1:0];
    assign diff     = r_tick_count - r_mark[wi];
    assign due      = r_en[wi] && !diff[TICK_W-1] && (diff >= TICK_W'(r_ticks[wi]));
    assign mask_ext = MAX_CHANNELS'(r_mask);

    assign o_sts.cfg_busy = r_cv1_v || r_cv2_v;

    // configuration writes and the conversion pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= P_RST_MASK;
            r_cv1_v <= 1'b0;
            r_cv2_v <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_ticks[k] <= RST_TICKS[CH_W'(k)];
            end
        end else begin
            r_cv1_v <= i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_PERIOD_REGS));
            r_cv2_v <= r_cv1_v;
            if (i_cfg_we && (i_cfg_index == CFG_MASK_IDX)) begin
                r_mask <= i_cfg_data[MASK_W-1:0];
            end
            if (r_cv2_v && ({1'b0, r_cv2_idx} < (CFG_IDX_W + 1)'(NUM_CHANNELS))) begin
                r_ticks[r_cv2_idx[IDX_W-1:0]] <= cv_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv1_ms  <= i_cfg_data[PERIOD_W-1:0];
        r_cv1_idx <= i_cfg_index;
        r_cv2_ms  <= r_cv1_ms;
        r_cv2_idx <= r_cv1_idx;
        r_prod    <= PROD_W'(r_cv1_ms) * PROD_W'(RECIP);
    end

    // tick count, marks, enables and results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_pend_v     <= 1'b0;
            r_pend_ch    <= '0;
            r_pend_cnt   <= '0;
            r_stb        <= 1'b0;
            r_fired      <= 1'b0;
            r_och        <= '0;
            r_ocnt       <= '0;
            r_last       <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_mark[k] <= '0;
                r_en[k]   <= 1'b0;
            end
        end else begin
            r_stb <= 1'b0;
            if (i_cmd.acc) begin
                r_pend_v   <= 1'b0;
                r_pend_cnt <= '0;
            end
            if (i_cmd.acc_tick) begin
                r_tick_count <= r_tick_count + TICK_W'(1);
            end
            if (i_cmd.acc_en && ({1'b0, i_cmd.en_ch} < (CH_W + 1)'(NUM_CHANNELS))) begin
                r_en[ei] <= i_cmd.en_val;
            end
            if (i_cmd.walk_start) begin
                r_mark[wi] <= r_tick_count - TICK_W'(r_ticks[wi]);
                r_en[wi]   <= (i_cmd.walk_ch < CH_W'(NUM_PERIOD_REGS)) &&
                              mask_ext[i_cmd.walk_ch];
            end
            if (i_cmd.walk_tick && due) begin
                r_mark[wi] <= r_mark[wi] + TICK_W'(r_ticks[wi]);
                r_pend_v   <= 1'b1;
                r_pend_ch  <= i_cmd.walk_ch;
                r_pend_cnt <= r_pend_cnt + CNT_W'(1);
                // flush the previous firing, now known not to be the last
                if (r_pend_v) begin
                    r_stb   <= 1'b1;
                    r_fired <= 1'b1;
                    r_och   <= r_pend_ch;
                    r_ocnt  <= r_pend_cnt;
                    r_last  <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_stb   <= 1'b1;
                r_fired <= r_pend_v;
                r_och   <= r_pend_v ? r_pend_ch : '0;
                r_ocnt  <= r_pend_v ? r_pend_cnt : '0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_strobe        = r_stb;
    assign o_fired         = r_fired;
    assign o_fired_channel = r_och;
    assign o_fired_count   = r_ocnt;
    assign o_last_result   = r_last;

endmodule

// ===== hdl/multi_rate_periodic_event_scheduler.sv =====
// Multi-rate periodic event scheduler, top level. Depends on mrpes_pkg, mrpes_ctrl, mrpes_dp.
// Timing: tick and start walk one channel per cycle; the final result word is registered from
//   the finishing state, which follows the walk, or follows accept for enable and disable.
// A new word is taken only once the controller is back in idle after the channel walk and the
//   finishing state. A period write holds busy while the reciprocal multiply converts it
//   to base ticks. Results cannot be stalled.
// Reset: synchronous, active low; restores register defaults, clears count, marks, enables.
module multi_rate_periodic_event_scheduler import mrpes_pkg::*; #(
    parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
    parameter int BASE_PERIOD_MS = DEF_BASE_PERIOD_MS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command side: a word is taken when start is high and busy is low
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [CH_W-1:0]      i_channel,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // result words, one cycle each, marked by o_strobe
    output logic                 o_strobe,
    output logic                 o_fired,
    output logic [CH_W-1:0]      o_fired_channel,
    output logic [CNT_W-1:0]     o_fired_count,
    output logic                 o_last_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: accept a word, then step a channel index through the
    // channels for tick and start, and close with a finishing state.
    mrpes_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_opcode  (i_opcode),
        .i_channel (i_channel),
        .i_cfg_we  (i_cfg_we),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Datapath: hold the registers, the tick count, a mark and an enable bit per
    // channel; hold back each firing one step so the last one can be flagged.
    mrpes_dp #(
        .NUM_CHANNELS   (NUM_CHANNELS),
        .BASE_PERIOD_MS (BASE_PERIOD_MS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_strobe        (o_strobe),
        .o_fired         (o_fired),
        .o_fired_channel (o_fired_channel),
        .o_fired_count   (o_fired_count),
        .o_last_result   (o_last_result)
    );

endmodule
